[hw/rtl/mfhp_pkg.sv]
// ----------------------------------------------------------------------------
// mfhp_pkg
// Shared types, constants and helpers for the music file header parser.
// ----------------------------------------------------------------------------
package mfhp_pkg;

  localparam int unsigned OffsetBits = 16;
  localparam int unsigned FieldBits  = 16;
  localparam int unsigned TailBits   = 32;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharEof   = 8'h1a;
  localparam logic [7:0] CharEsc   = 8'h1b;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDot   = 8'h2e;
  localparam logic [7:0] CharLowP  = 8'h70;
  localparam logic [7:0] CharLowD  = 8'h64;
  localparam logic [7:0] CharLowX  = 8'h78;
  localparam logic [7:0] CaseBit   = 8'h20;

  typedef enum logic [6:0] {
    PhTitle  = 7'b0000001,
    PhAlign  = 7'b0000010,
    PhScanCr = 7'b0000100,
    PhScanEf = 7'b0001000,
    PhName   = 7'b0010000,
    PhBody   = 7'b0100000,
    PhDone   = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StBadTitle  = 2'd1,
    StTruncated = 2'd2,
    StTooLong   = 2'd3
  } status_e;

  typedef struct packed {
    phase_e                phase;
    logic [OffsetBits-1:0] offset;
    logic                  ended_cr;
    logic [OffsetBits-1:0] name_off;
    logic                  has_name;
    logic [TailBits-1:0]   tail;
    logic [FieldBits-1:0]  count;
  } state_t;

  typedef struct packed {
    status_e              status;
    logic                 has_sample_file;
    logic [FieldBits-1:0] name_offset;
    logic [FieldBits-1:0] name_length;
    logic                 name_has_ext;
    logic [FieldBits-1:0] body_offset;
  } result_t;

  localparam state_t StateReset = '{
    phase:    PhTitle,
    offset:   '0,
    ended_cr: 1'b0,
    name_off: '0,
    has_name: 1'b0,
    tail:     '0,
    count:    '0
  };

  function automatic logic [FieldBits-1:0] to_field(input logic [OffsetBits-1:0] v);
    logic [OffsetBits+FieldBits-1:0] w;
    w = {{FieldBits{1'b0}}, v};
    return w[FieldBits-1:0];
  endfunction

endpackage

[hw/rtl/mfhp_step.sv]
// ----------------------------------------------------------------------------
// mfhp_step
// Next-state and result logic for one byte of the file image.
// ----------------------------------------------------------------------------
module mfhp_step import mfhp_pkg::*; (
  input  state_t     cur_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output state_t     nxt_o,
  output logic       res_valid_o,
  output result_t    res_o
);

  state_t  nxt;
  logic    res_v;
  status_e st;
  logic    bad;
  logic    at_max;
  logic    is_ext;

  assign at_max = (cur_i.offset == {OffsetBits{1'b1}});
  assign is_ext = (cur_i.count >= FieldBits'(4))
      && (cur_i.tail[31:24] == CharDot)
      && ((cur_i.tail[23:16] | CaseBit) == CharLowP)
      && ((cur_i.tail[15:8] | CaseBit) == CharLowD)
      && ((cur_i.tail[7:0] | CaseBit) == CharLowX);

  always_comb begin
    nxt   = cur_i;
    res_v = 1'b0;
    st    = StOk;
    bad   = 1'b0;
    case (cur_i.phase)
      PhDone: begin
      end
      PhBody: begin
        res_v = 1'b1;
      end
      default: begin
        case (cur_i.phase)
          PhTitle: begin
            if (data_byte_i == CharCr || data_byte_i == CharLf) begin
              nxt.ended_cr = (data_byte_i == CharCr);
              if (!cur_i.offset[0]) begin
                nxt.phase = PhAlign;
              end else begin
                nxt.phase = (data_byte_i == CharCr) ? PhScanEf : PhScanCr;
              end
            end else if (data_byte_i < CharSpace &&
                         !(data_byte_i inside {CharTab, CharEsc})) begin
              bad = 1'b1;
            end
          end
          PhAlign: begin
            nxt.phase = cur_i.ended_cr ? PhScanEf : PhScanCr;
          end
          PhScanCr: begin
            if (data_byte_i == CharCr) nxt.phase = PhScanEf;
          end
          PhScanEf: begin
            if (data_byte_i == CharEof) begin
              nxt.name_off = cur_i.offset + OffsetBits'(1);
              nxt.phase    = PhName;
            end
          end
          PhName: begin
            if (cur_i.offset == cur_i.name_off) nxt.has_name = (data_byte_i != CharNul);
            if (data_byte_i == CharNul) begin
              nxt.phase = PhBody;
            end else begin
              nxt.tail = {cur_i.tail[TailBits-9:0], data_byte_i};
              if (cur_i.count != {FieldBits{1'b1}}) nxt.count = cur_i.count + FieldBits'(1);
            end
          end
          default: begin
          end
        endcase
        if (bad) begin
          res_v = 1'b1;
          st    = StBadTitle;
        end else if (at_max) begin
          res_v = 1'b1;
          st    = StTooLong;
        end else begin
          nxt.offset = cur_i.offset + OffsetBits'(1);
        end
      end
    endcase
    if (!res_v && last_byte_i && cur_i.phase != PhDone) begin
      res_v = 1'b1;
      st    = StTruncated;
    end
    if (last_byte_i) begin
      nxt = StateReset;
    end else if (res_v) begin
      nxt.phase = PhDone;
    end
  end

  always_comb begin
    res_o        = '0;
    res_o.status = st;
    if (st == StOk) begin
      res_o.has_sample_file = cur_i.has_name;
      res_o.name_offset     = to_field(cur_i.name_off);
      res_o.name_length     = cur_i.count;
      res_o.name_has_ext    = is_ext;
      res_o.body_offset     = to_field(cur_i.offset);
    end
  end

  assign nxt_o       = nxt;
  assign res_valid_o = res_v;

endmodule

[hw/rtl/music_file_header_parser.sv]
// ----------------------------------------------------------------------------
// music_file_header_parser
// Streams a music file image byte by byte and reports header layout.
// ----------------------------------------------------------------------------
// usage
//   input channel: one image byte per beat on data_byte_i, last_byte_i high
//   on the final byte of the image; in_valid_i / in_stall_o handshake
//   output channel: at most one result beat per image on status_o and the
//   layout fields; out_valid_o / out_stall_i handshake
//   throughput: one byte per cycle while in_stall_o is low, set by the
//   single register stage holding the parse state and the result register
//   result: registered from the byte that causes it, shown in the next cycle
//   (first body byte, bad title byte, overflow or early end of image)
//   bytes after a result are dropped until the last-byte mark, which rearms
//   the parser for the next image
//   stall: while a result waits and out_stall_i is high, in_stall_o is high;
//   a byte is taken in the same cycle as the waiting result leaves
//   reset: parser back to the title phase, no result pending
// ----------------------------------------------------------------------------
module music_file_header_parser import mfhp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic                 has_sample_file_o,
  output logic [FieldBits-1:0] name_offset_o,
  output logic [FieldBits-1:0] name_length_o,
  output logic                 name_has_extension_o,
  output logic [FieldBits-1:0] body_offset_o
);

  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    res_valid;
  logic    out_valid_q;
  logic    accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  mfhp_step u_step (
    .cur_i       (state_q),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .nxt_o       (state_d),
    .res_valid_o (res_valid),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) state_q <= state_d;
      if (accept && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) res_q <= res_d;
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = res_q.status;
  assign has_sample_file_o    = res_q.has_sample_file;
  assign name_offset_o        = res_q.name_offset;
  assign name_length_o        = res_q.name_length;
  assign name_has_extension_o = res_q.name_has_ext;
  assign body_offset_o        = res_q.body_offset;

endmodule

[hw/rtl/mfhp_checker.sv]
// ----------------------------------------------------------------------------
// mfhp_checker
// Port-level checks for the music file header parser, bound to the top level.
// ----------------------------------------------------------------------------
module mfhp_checker import mfhp_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [1:0]           status_o,
  input logic                 has_sample_file_o,
  input logic [FieldBits-1:0] name_offset_o,
  input logic [FieldBits-1:0] name_length_o,
  input logic                 name_has_extension_o,
  input logic [FieldBits-1:0] body_offset_o
);

  // held result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(body_offset_o) && $stable(name_length_o))
    else $error("stalled result beat changed");

  // input is only held back by a blocked result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // error results carry no layout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> !has_sample_file_o && name_offset_o == '0
      && name_length_o == '0 && !name_has_extension_o && body_offset_o == '0)
    else $error("error result with layout fields set");

  // an extension match needs at least four name bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && name_has_extension_o |-> name_length_o >= FieldBits'(4))
    else $error("extension flagged on a short name");

endmodule

bind music_file_header_parser mfhp_checker u_mfhp_checker (.*);

[test/music_file_header_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// music_file_header_parser_tb
// Streams file images through the parser and checks every layout result.
// A short table of hand-built images comes first, then two images that run
// the offset counter to its top, then a long run of random images. Most of
// the random images are well formed, and some are cut short, corrupted or
// plain noise. A behavioural model of the parser predicts each result, and
// the results are compared in order. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module music_file_header_parser_tb import mfhp_pkg::*;;

  localparam int CycleLimit  = 1_000_000;
  localparam int RandomBeats = 1600;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
    logic       typed;
    result_t    want;
  } row_t;

  localparam result_t Blank = '{StOk, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0};

  localparam row_t Script [23] = '{
    '{8'h20, 1'b0, 1'b0, Blank},
    '{8'h0d, 1'b0, 1'b0, Blank},
    '{8'h1a, 1'b0, 1'b0, Blank},
    '{8'h2e, 1'b0, 1'b0, Blank},
    '{8'h70, 1'b0, 1'b0, Blank},
    '{8'h44, 1'b0, 1'b0, Blank},
    '{8'h78, 1'b0, 1'b0, Blank},
    '{8'h00, 1'b0, 1'b0, Blank},
    '{8'h5a, 1'b1, 1'b1, '{StOk, 1'b1, 16'd3, 16'd4, 1'b1, 16'd8}},
    '{8'h00, 1'b0, 1'b1, '{StBadTitle, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0}},
    '{8'hff, 1'b1, 1'b0, Blank},
    '{8'h09, 1'b0, 1'b0, Blank},
    '{8'h1b, 1'b0, 1'b0, Blank},
    '{8'h0a, 1'b0, 1'b0, Blank},
    '{8'h00, 1'b0, 1'b0, Blank},
    '{8'h1a, 1'b0, 1'b0, Blank},
    '{8'h0d, 1'b0, 1'b0, Blank},
    '{8'h1a, 1'b0, 1'b0, Blank},
    '{8'h00, 1'b0, 1'b0, Blank},
    '{8'hff, 1'b0, 1'b0, Blank},
    '{8'h00, 1'b1, 1'b0, Blank},
    '{8'h5a, 1'b1, 1'b1, '{StTruncated, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0}},
    '{8'h1f, 1'b1, 1'b1, '{StBadTitle, 1'b0, 16'd0, 16'd0, 1'b0, 16'd0}}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [7:0]           data_byte_i;
  logic                 last_byte_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [1:0]           status_o;
  logic                 has_sample_file_o;
  logic [FieldBits-1:0] name_offset_o;
  logic [FieldBits-1:0] name_length_o;
  logic                 name_has_extension_o;
  logic [FieldBits-1:0] body_offset_o;

  logic    pinned;
  result_t pinned_layout;
  logic    calm;

  // parser model state
  phase_e      ph;
  logic [15:0] pos;
  logic        cr_end;
  logic [15:0] name_start;
  logic        name_seen;
  logic [31:0] tail4;
  logic [15:0] name_bytes;

  result_t    layouts_due [$];
  logic [7:0] image_bytes [$];
  result_t    layout_now;
  result_t    layout_want;
  result_t    layout_got;
  logic       layout_hit;
  int         faults;
  int         busy_beats;
  int         cycles;
  int         images;
  int         seen_status [4];

  music_file_header_parser uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .data_byte_i         (data_byte_i),
    .last_byte_i         (last_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .has_sample_file_o   (has_sample_file_o),
    .name_offset_o       (name_offset_o),
    .name_length_o       (name_length_o),
    .name_has_extension_o(name_has_extension_o),
    .body_offset_o       (body_offset_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic logic [7:0] pick_byte(input int lo, input int hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic logic [7:0] case_flip();
    return ($urandom_range(0, 1) != 0) ? CaseBit : 8'h00;
  endfunction

  function automatic logic [7:0] title_char();
    int roll;
    roll = $urandom_range(0, 39);
    if (roll == 0) return pick_byte(0, 31);
    if (roll < 5) return roll[0] ? CharTab : CharEsc;
    return pick_byte(32, 255);
  endfunction

  task automatic clear_parser();
    ph         = PhTitle;
    pos        = '0;
    cr_end     = 1'b0;
    name_start = '0;
    name_seen  = 1'b0;
    tail4      = '0;
    name_bytes = '0;
  endtask

  task automatic predict_layout(input logic [7:0] b, input logic last, output logic hit,
                                output result_t r);
    status_e st;
    logic    bad;
    hit = 1'b0;
    bad = 1'b0;
    st  = StOk;
    r   = Blank;
    if (ph == PhDone) begin
      if (last) clear_parser();
      return;
    end
    if (ph == PhBody) begin
      hit = 1'b1;
    end else begin
      case (ph)
        PhTitle: begin
          if (b == CharCr || b == CharLf) begin
            cr_end = (b == CharCr);
            if (!pos[0]) ph = PhAlign;
            else if (cr_end) ph = PhScanEf;
            else ph = PhScanCr;
          end else if (b < CharSpace && b != CharTab && b != CharEsc) begin
            bad = 1'b1;
          end
        end
        PhAlign: begin
          if (cr_end) ph = PhScanEf;
          else ph = PhScanCr;
        end
        PhScanCr: begin
          if (b == CharCr) ph = PhScanEf;
        end
        PhScanEf: begin
          if (b == CharEof) begin
            name_start = pos + 16'd1;
            ph = PhName;
          end
        end
        default: begin
          if (pos == name_start) name_seen = (b != CharNul);
          if (b == CharNul) begin
            ph = PhBody;
          end else begin
            tail4 = {tail4[23:0], b};
            if (name_bytes != 16'hffff) name_bytes++;
          end
        end
      endcase
      if (bad) begin
        hit = 1'b1;
        st  = StBadTitle;
      end else if (pos == '1) begin
        hit = 1'b1;
        st  = StTooLong;
      end else begin
        pos++;
      end
    end
    if (!hit && last) begin
      hit = 1'b1;
      st  = StTruncated;
    end
    if (hit) begin
      r.status = st;
      if (st == StOk) begin
        r.has_sample_file = name_seen;
        r.name_offset     = name_start;
        r.name_length     = name_bytes;
        r.name_has_ext    = name_bytes >= 16'd4 && tail4[31:24] == CharDot
                            && (tail4[23:16] | CaseBit) == CharLowP
                            && (tail4[15:8] | CaseBit) == CharLowD
                            && (tail4[7:0] | CaseBit) == CharLowX;
        r.body_offset     = pos;
      end
    end
    if (last) clear_parser();
    else if (hit) ph = PhDone;
  endtask

  // input beats feed the model, output beats are checked against it
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (ph != PhDone) busy_beats++;
        predict_layout(data_byte_i, last_byte_i, layout_hit, layout_now);
        if (pinned) layouts_due.push_back(pinned_layout);
        else if (layout_hit) layouts_due.push_back(layout_now);
      end
      if (out_valid_o && !out_stall_i) begin
        layout_got = '{status_e'(status_o), has_sample_file_o, name_offset_o,
                       name_length_o, name_has_extension_o, body_offset_o};
        seen_status[status_o]++;
        if (layouts_due.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("result beat with none due: status %0d body offset %0d",
                     status_o, body_offset_o);
        end else begin
          layout_want = layouts_due.pop_front();
          if (layout_got.status != layout_want.status
              || layout_got.has_sample_file != layout_want.has_sample_file
              || layout_got.name_offset != layout_want.name_offset
              || layout_got.name_length != layout_want.name_length
              || layout_got.name_has_ext != layout_want.name_has_ext
              || layout_got.body_offset != layout_want.body_offset) begin
            faults++;
            if (faults <= 10) begin
              $display("layout mismatch (expected/actual): status %0d/%0d file %0d/%0d",
                       layout_want.status, layout_got.status,
                       layout_want.has_sample_file, layout_got.has_sample_file);
              $display("  name offset %0d/%0d length %0d/%0d ext %0d/%0d body %0d/%0d",
                       layout_want.name_offset, layout_got.name_offset,
                       layout_want.name_length, layout_got.name_length,
                       layout_want.name_has_ext, layout_got.name_has_ext,
                       layout_want.body_offset, layout_got.body_offset);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: stall a drawn number of cycles on each result
  initial begin
    int hold;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 10);
      @(negedge clk_i);
      out_stall_i <= (hold != 0);
      if (hold != 0) begin
        do @(posedge clk_i); while (!out_valid_o);
        repeat (hold) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin, input logic pin,
                           input result_t pin_want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i  <= 1'b0;
      data_byte_i <= pick_byte(0, 255);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    last_byte_i   <= fin;
    pinned        <= pin;
    pinned_layout <= pin_want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_image();
    foreach (image_bytes[i])
      send_byte(image_bytes[i], logic'(i == image_bytes.size() - 1), 1'b0, Blank);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (layouts_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic build_image();
    int  kind;
    int  cut;
    int  at;
    logic lf;
    image_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 20)) image_bytes.push_back(pick_byte(0, 255));
    end else begin
      repeat ($urandom_range(0, 12)) image_bytes.push_back(title_char());
      lf = ($urandom_range(0, 1) != 0);
      image_bytes.push_back(lf ? CharLf : CharCr);
      if (image_bytes.size() % 2 == 1) image_bytes.push_back(pick_byte(0, 255));
      if (lf) begin
        repeat ($urandom_range(0, 4)) image_bytes.push_back(pick_byte(0, 255));
        image_bytes.push_back(CharCr);
      end
      repeat ($urandom_range(0, 4)) image_bytes.push_back(pick_byte(0, 255));
      image_bytes.push_back(CharEof);
      if ($urandom_range(0, 4) != 0) begin
        repeat ($urandom_range(0, 8)) image_bytes.push_back(pick_byte(1, 255));
        case ($urandom_range(0, 3))
          0, 1: begin
            image_bytes.push_back(CharDot);
            image_bytes.push_back(CharLowP ^ case_flip());
            image_bytes.push_back(CharLowD ^ case_flip());
            image_bytes.push_back(CharLowX ^ case_flip());
          end
          2: begin
            image_bytes.push_back(CharDot);
            repeat (3) image_bytes.push_back(pick_byte(1, 255));
          end
          default: ;
        endcase
      end
      image_bytes.push_back(CharNul);
      repeat ($urandom_range(1, 5)) image_bytes.push_back(pick_byte(0, 255));
      if (kind == 1) begin
        cut = $urandom_range(1, image_bytes.size());
        while (image_bytes.size() > cut) void'(image_bytes.pop_back());
      end else if (kind == 2) begin
        at = $urandom_range(0, image_bytes.size() - 1);
        image_bytes[at] = pick_byte(0, 255);
      end
    end
  endtask

  initial begin
    int start_beats;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    last_byte_i = 1'b0;
    pinned      = 1'b0;
    pinned_layout = Blank;
    calm        = 1'b0;
    faults      = 0;
    busy_beats  = 0;
    cycles      = 0;
    images      = 0;
    foreach (seen_status[i]) seen_status[i] = 0;
    clear_parser();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (Script[i]) send_byte(Script[i].b, Script[i].fin, Script[i].typed, Script[i].want);
    drain_results();

    // title that runs the offset counter to its top
    calm = 1'b1;
    image_bytes.delete();
    repeat (65536) image_bytes.push_back(pick_byte(32, 255));
    image_bytes.push_back(CharNul);
    send_image();
    drain_results();

    // body beat landing on the top offset
    image_bytes.delete();
    repeat (65527) image_bytes.push_back(pick_byte(32, 255));
    image_bytes.push_back(CharCr);
    image_bytes.push_back(CharEof);
    image_bytes.push_back(CharLowX);
    image_bytes.push_back(CharDot);
    image_bytes.push_back(CharLowP ^ CaseBit);
    image_bytes.push_back(CharLowD);
    image_bytes.push_back(CharLowX ^ CaseBit);
    image_bytes.push_back(CharNul);
    image_bytes.push_back(pick_byte(0, 255));
    send_image();
    drain_results();

    start_beats = busy_beats;
    while (busy_beats - start_beats < RandomBeats) begin
      calm = ($urandom_range(0, 7) == 0);
      build_image();
      send_image();
      images++;
      if (images % 16 == 0) drain_results();
    end
    calm = 1'b0;
    drain_results();
    repeat (8) @(posedge clk_i);

    $display("%0d header beats parsed: table, two full-range images, %0d random images",
             busy_beats, images);
    $display("results by status: ok %0d, bad title %0d, truncated %0d, too long %0d",
             seen_status[0], seen_status[1], seen_status[2], seen_status[3]);
    if (faults == 0 && layouts_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
